>>> sv/modexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and the stage word for the modular exponentiation pipeline.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int BASE_W       = 32;
  localparam int EXP_W        = 31;
  localparam int RES_W        = 30;
  localparam int PROD_W       = 2 * RES_W;
  localparam int C_EXP_BITS   = 31;
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [RES_W-1:0]  PRIME  = 30'd1000000007;
  // floor(2^60 / PRIME), Barrett constant
  localparam logic [30:0]       MU     = 31'd1152921496;
  localparam logic [BASE_W-1:0] PRIME1 = 32'd1000000007;
  localparam logic [BASE_W-1:0] PRIME2 = 32'd2000000014;
  localparam logic [BASE_W-1:0] PRIME3 = 32'd3000000021;
  localparam logic [BASE_W-1:0] PRIME4 = 32'd4000000028;

  typedef struct packed {
    logic             valid;
    logic [RES_W-1:0] acc;
    logic [RES_W-1:0] sq;
    logic [EXP_W-1:0] exp;
  } mx_stage_t;

endpackage

>>> sv/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// One base reduction stage, then four stages per exponent bit (multiply,
// two Barrett multiplies, final correction). Throughput: one word per
// cycle; the whole chain holds when the output word is not taken. Reset
// (synchronous, rst_n low) clears every valid bit; nothing else needs
// clearing.
// ----------------------------------------------------------------------------
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int EXP_BITS = C_EXP_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // base_value[31:0], exponent[62:32]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // power_mod[29:0]
);

  mx_stage_t             chain [EXP_BITS+1];
  logic                  adv;
  logic                  v0_r;
  logic [RES_W-1:0]      sq0_r;
  logic [EXP_W-1:0]      exp0_r;
  logic [BASE_W-1:0]     base;
  logic [BASE_W-1:0]     base_red;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign base      = in_tdata[BASE_W-1:0];

  always_comb begin
    priority if (base >= PRIME4) base_red = base - PRIME4;
    else if (base >= PRIME3)     base_red = base - PRIME3;
    else if (base >= PRIME2)     base_red = base - PRIME2;
    else if (base >= PRIME1)     base_red = base - PRIME1;
    else                         base_red = base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0_r  <= base_red[RES_W-1:0];
      exp0_r <= in_tdata[BASE_W+EXP_W-1:BASE_W];
    end
  end

  assign chain[0].valid = v0_r;
  assign chain[0].acc   = RES_W'(1);
  assign chain[0].sq    = sq0_r;
  assign chain[0].exp   = exp0_r;

  for (genvar i = 0; i < EXP_BITS; i++) begin : g_bit
    modexp_bit #(.BIT_IDX(i)) u_bit (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .s_in  (chain[i]),
      .s_out (chain[i+1])
    );
  end

  assign out_tvalid = chain[EXP_BITS].valid;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, chain[EXP_BITS].acc};

endmodule

>>> sv/modexp_red.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_red
// Three-stage Barrett reduction of a 60-bit product modulo the prime.
// ----------------------------------------------------------------------------
module modexp_red
  import modexp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] x,
  output logic [RES_W-1:0]  r
);

  logic [61:0]       q2_r;
  logic [PROD_W-1:0] xa_r;
  logic [60:0]       qp_r;
  logic [31:0]       xb_r;
  logic [RES_W-1:0]  r_r;
  logic [31:0]       d0, d1, d2;

  always_ff @(posedge clk) begin
    if (en) begin
      q2_r <= {2'b0, x[PROD_W-1:29]} * {31'b0, MU};
      xa_r <= x;
      qp_r <= {30'b0, q2_r[61:31]} * {31'b0, PRIME};
      xb_r <= xa_r[31:0];
      r_r  <= d0 >= PRIME2 ? d2[RES_W-1:0] :
              d0 >= PRIME1 ? d1[RES_W-1:0] : d0[RES_W-1:0];
    end
  end

  // remainder is below three times the prime
  assign d0 = xb_r - qp_r[31:0];
  assign d1 = d0 - PRIME1;
  assign d2 = d0 - PRIME2;
  assign r  = r_r;

endmodule

>>> sv/modexp_bit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_bit
// One exponent bit: multiply, then reduce acc and square.
// ----------------------------------------------------------------------------
module modexp_bit
  import modexp_pkg::*;
#(
  parameter int BIT_IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  mx_stage_t s_in,
  output mx_stage_t s_out
);

  logic [PROD_W-1:0] pa_r, ps_r;
  logic [3:0]        vld_r;
  logic [EXP_W-1:0]  exp_r [4];
  logic [RES_W-1:0]  mop;
  logic [RES_W-1:0]  acc_red, sq_red;

  assign mop = s_in.exp[BIT_IDX] ? s_in.sq : RES_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], s_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= {{RES_W{1'b0}}, s_in.acc} * {{RES_W{1'b0}}, mop};
      ps_r     <= {{RES_W{1'b0}}, s_in.sq} * {{RES_W{1'b0}}, s_in.sq};
      exp_r[0] <= s_in.exp;
      exp_r[1] <= exp_r[0];
      exp_r[2] <= exp_r[1];
      exp_r[3] <= exp_r[2];
    end
  end

  modexp_red u_red_acc (.clk(clk), .en(en), .x(pa_r), .r(acc_red));
  modexp_red u_red_sq  (.clk(clk), .en(en), .x(ps_r), .r(sq_red));

  assign s_out.valid = vld_r[3];
  assign s_out.acc   = acc_red;
  assign s_out.sq    = sq_red;
  assign s_out.exp   = exp_r[3];

endmodule

>>> sv/modexp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_chk
// Port-level checks for modular_exponentiation, bound to the top level.
// ----------------------------------------------------------------------------
module modexp_chk
  import modexp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word dropped or changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata < {2'b0, PRIME})
    else $error("result not reduced");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

endmodule

bind modular_exponentiation modexp_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/modexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_checker
// Watches both stream channels of the modular exponentiation block, computes
// base^exponent mod 1000000007 for every accepted input word and compares each
// accepted output word against the oldest pending power in order.
// ----------------------------------------------------------------------------
module modexp_checker
  import modexp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending_powers
);

  localparam logic [63:0] MODULUS = 64'd1000000007;

  logic [RES_W-1:0] power_queue[$];

  function automatic logic [RES_W-1:0] power_mod_of(logic [BASE_W-1:0] base_value,
                                                    logic [EXP_W-1:0] exponent);
    logic [63:0] square;
    logic [63:0] product;
    square  = {32'd0, base_value} % MODULUS;
    product = 64'd1;
    for (int i = 0; i < C_EXP_BITS; i++) begin
      if (exponent[i]) product = (product * square) % MODULUS;
      square = (square * square) % MODULUS;
    end
    return product[RES_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count     = 0;
    pending_powers = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      power_queue.push_back(power_mod_of(in_tdata[31:0], in_tdata[62:32]));
    if (rst_n && out_tvalid && out_tready) begin
      if (power_queue.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_tdata), 64'd0);
      end else begin
        logic [RES_W-1:0] want;
        want = power_queue.pop_front();
        if (out_tdata[RES_W-1:0] !== want)
          report_mismatch("power_mod", 64'(out_tdata[RES_W-1:0]), 64'(want));
        if (out_tdata[OUT_TDATA_W-1:RES_W] !== '0)
          report_mismatch("pad bits", 64'(out_tdata[OUT_TDATA_W-1:RES_W]), 64'd0);
      end
    end
    pending_powers = power_queue.size();
  end

endmodule

>>> dv/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Drives directed and random base/exponent words in bursts with a randomly
// stalling receiver, including one long hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  import modexp_pkg::*;

  localparam int LATENCY   = 1 + 4 * C_EXP_BITS;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 250;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     pending_powers;
  int                     idle_cycles;
  bit                     hold_off;

  modular_exponentiation dut (.*);

  modexp_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_tready <= ~out_tready;
      else out_tready <= ($urandom_range(0, 9) != 0);
    end
  end

  // watchdog: count cycles with no word moving on either side, outside the hold-off
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("[modular_exponentiation] ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [BASE_W-1:0] base_value, logic [EXP_W-1:0] exponent);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, exponent, base_value};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_gap();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [EXP_W-1:0] random_exponent();
    case ($urandom_range(0, 4))
      0: return EXP_W'($urandom_range(0, 15));
      1: return EXP_W'({$urandom} >> $urandom_range(1, 31));
      default: return EXP_W'($urandom);
    endcase
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return PRIME1 * $urandom_range(0, 4) + $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    hold_off    = 1'b0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_word(32'd0, 31'd0);
    send_word(PRIME1, 31'd0);
    send_word(32'hFFFF_FFFF, 31'd0);
    send_word(32'd0, 31'd1);
    send_word(32'd0, 31'h7FFF_FFFF);
    send_word(32'd1, 31'h7FFF_FFFF);
    send_word(32'd2, 31'd29);
    send_word(32'd2, 31'd30);
    send_word(32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF, 31'd1);
    send_word(PRIME1 - 1, 31'd2);
    send_word(PRIME1, 31'd5);
    send_word(PRIME2 + 32'd3, 31'd7);
    send_word(PRIME3, 31'h4000_0000);
    send_word(PRIME4 + 32'd1, 31'h5555_5555);
    send_word(32'hAAAA_AAAA, 31'h2AAA_AAAA);
    send_word(32'd1000000006, 31'd1000000006);
    send_word(32'd12345, 31'd1000000005);

    // long receiver hold-off while words keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 2 * LATENCY; i++) send_word(random_base(), random_exponent());
    join

    for (int i = 0; i < N_RANDOM; i++) begin
      send_word(random_base(), random_exponent());
      if ($urandom_range(0, 7) == 0) send_gap();
    end
    in_tvalid <= 1'b0;

    while (pending_powers != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending_powers == 0)
      $display("[modular_exponentiation] OK");
    else
      $display("[modular_exponentiation] ERROR");
    $finish;
  end

endmodule
